// File: rtl/line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Line rasteriser assertion macros
// Concurrent assertion shorthands clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasteriser package
// Shared item types, line modes and command/status bundles.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS = 10;
    localparam int COLOR_BITS = 8;

    // Command field encoding.
    localparam logic CMD_START = 1'b0;

    typedef logic [COORD_BITS-1:0] lr_coord_t;
    typedef logic [COLOR_BITS-1:0] lr_color_t;

    typedef enum logic [1:0] {
        MODE_HORIZ   = 2'd0,
        MODE_VERT    = 2'd1,
        MODE_STEEP   = 2'd2,
        MODE_SHALLOW = 2'd3
    } lr_mode_t;

    typedef struct packed {
        logic      command;
        lr_coord_t x_start;
        lr_coord_t y_start;
        lr_coord_t x_end;
        lr_coord_t y_end;
        lr_color_t line_color;
    } lr_in_t;

    typedef struct packed {
        lr_coord_t pixel_x;
        lr_coord_t pixel_y;
        lr_color_t pixel_color;
        logic      pixel_valid;
        logic      last_pixel;
    } lr_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_load;
    } lr_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_div;
        logic div_busy;
    } lr_stat_t;

endpackage

// File: rtl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// Line rasteriser
// A start item loads two endpoints and a colour and gives the first pixel; each
// step item gives the next pixel, with last_pixel marking the endpoint. Step
// items, and starts of horizontal, vertical or exact diagonal lines, are taken
// one per cycle while the receiver keeps the result register free. Any other
// start runs the serial slope divider, one quotient bit per cycle, and the
// input stays not ready until the slope is loaded; the first pixel is already
// in the result register meanwhile. Results sit in a one-deep output register.
// ----------------------------------------------------------------------------
`include "line_rasterizer_assert.svh"

module line_rasterizer
    import lr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  lr_in_t  s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output lr_out_t m_data
);

    lr_cmd_t  cmd;
    lr_stat_t stat;
    logic     idle_zero;

    lr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .m_data  (m_data),
        .stat    (stat)
    );

    assign idle_zero = (m_data.pixel_x == '0) && (m_data.pixel_y == '0)
                       && (m_data.pixel_color == '0) && !m_data.last_pixel;

    `LR_ASSERT_NEXT(a_div_blocks_input, cmd.div_start, !s_ready, "input ready after a divide start")
    `LR_ASSERT_SAME(a_ready_while_div, stat.div_busy, !s_ready, "input ready while divider runs")
    `LR_ASSERT_SAME(a_idle_zero, m_valid && !m_data.pixel_valid, idle_zero, "idle result not zero")

endmodule

// File: rtl/lr_div.sv
// ----------------------------------------------------------------------------
// Line rasteriser slope divider
// Restoring divider giving numer * 2^FRAC_BITS / denom, one bit per cycle.
// ----------------------------------------------------------------------------
module lr_div
    import lr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  lr_coord_t            numer,
    input  lr_coord_t            denom,
    output logic                 busy,
    output logic [FRAC_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 run_reg, run_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    lr_coord_t            rem_reg, rem_next;
    lr_coord_t            den_reg, den_next;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;

    logic [COORD_BITS:0] trial;
    logic [COORD_BITS:0] diff;
    logic                fits;

    // The numerator is always below the denominator, so the remainder fits
    // the coordinate width and every quotient bit is fractional.
    always_comb begin
        trial = {rem_reg, 1'b0};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};

        run_next = run_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(FRAC_BITS);
            rem_next = numer;
            den_next = denom;
            quo_next = '0;
        end else if (run_reg) begin
            rem_next = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            quo_next = {quo_reg[FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            run_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy     = run_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/lr_datapath.sv
// ----------------------------------------------------------------------------
// Line rasteriser datapath
// Line set-up, pixel stepping with the error accumulator, and result register.
// ----------------------------------------------------------------------------
module lr_datapath
    import lr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  lr_in_t   s_data,
    input  lr_cmd_t  cmd,
    output lr_out_t  m_data,
    output lr_stat_t stat
);

    lr_coord_t            cur_x_reg, cur_x_next;
    lr_coord_t            cur_y_reg, cur_y_next;
    logic                 x_neg_reg, x_neg_next;
    lr_coord_t            steps_reg, steps_next;
    logic [FRAC_BITS-1:0] acc_reg, acc_next;
    logic [FRAC_BITS-1:0] estep_reg, estep_next;
    lr_mode_t             mode_reg, mode_next;
    lr_color_t            color_reg, color_next;
    logic                 busy_reg, busy_next;
    lr_out_t              out_reg, out_next;

    // Set-up of a new line.
    logic      swap;
    lr_coord_t x0, y0, x1, y1;
    lr_coord_t dx, dy, major, minor;
    logic      x_neg_s, steep;
    lr_mode_t  mode_s;

    // One pixel step.
    logic [FRAC_BITS-1:0] acc_sum;
    logic                 wrap;
    lr_coord_t            col_step, row_step;
    lr_coord_t            x_st, y_st, steps_st;
    logic [FRAC_BITS-1:0] acc_st;

    logic                 div_busy;
    logic [FRAC_BITS-1:0] quotient;

    always_comb begin
        swap    = s_data.y_start > s_data.y_end;
        x0      = swap ? s_data.x_end   : s_data.x_start;
        y0      = swap ? s_data.y_end   : s_data.y_start;
        x1      = swap ? s_data.x_start : s_data.x_end;
        y1      = swap ? s_data.y_start : s_data.y_end;
        dy      = y1 - y0;
        x_neg_s = x1 < x0;
        dx      = x_neg_s ? x0 - x1 : x1 - x0;
        steep   = dy > dx;
        major   = steep ? dy : dx;
        minor   = steep ? dx : dy;
        priority if (dy == '0) begin
            mode_s = MODE_HORIZ;
        end else if (dx == '0) begin
            mode_s = MODE_VERT;
        end else if (steep) begin
            mode_s = MODE_STEEP;
        end else begin
            mode_s = MODE_SHALLOW;
        end
    end

    // Equal deltas give a slope that truncates to zero, so no divide is run.
    assign stat.need_div = (s_data.command == CMD_START) && (dx != '0) && (dy != '0)
                           && (dx != dy);
    assign stat.div_busy = div_busy;

    always_comb begin
        acc_sum  = acc_reg + estep_reg;
        wrap     = acc_sum <= acc_reg;
        col_step = x_neg_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
        row_step = cur_y_reg + COORD_BITS'(1);
        steps_st = steps_reg - COORD_BITS'(1);
        x_st     = cur_x_reg;
        y_st     = cur_y_reg;
        acc_st   = acc_reg;
        unique case (mode_reg)
            MODE_HORIZ: begin
                x_st = col_step;
            end
            MODE_VERT: begin
                y_st = row_step;
            end
            MODE_STEEP: begin
                acc_st = acc_sum;
                y_st   = row_step;
                if (wrap) begin
                    x_st = col_step;
                end
            end
            MODE_SHALLOW: begin
                acc_st = acc_sum;
                x_st   = col_step;
                if (wrap) begin
                    y_st = row_step;
                end
            end
            default: begin
                x_st = cur_x_reg;
            end
        endcase
    end

    always_comb begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        x_neg_next = x_neg_reg;
        steps_next = steps_reg;
        acc_next   = acc_reg;
        estep_next = estep_reg;
        mode_next  = mode_reg;
        color_next = color_reg;
        busy_next  = busy_reg;
        out_next   = out_reg;

        if (cmd.accept) begin
            if (s_data.command == CMD_START) begin
                cur_x_next = x0;
                cur_y_next = y0;
                x_neg_next = x_neg_s;
                steps_next = major;
                acc_next   = '0;
                estep_next = '0;
                mode_next  = mode_s;
                color_next = s_data.line_color;
                busy_next  = major != '0;
                out_next   = '{pixel_x: x0, pixel_y: y0, pixel_color: s_data.line_color,
                               pixel_valid: 1'b1, last_pixel: major == '0};
            end else if (busy_reg) begin
                cur_x_next = x_st;
                cur_y_next = y_st;
                acc_next   = acc_st;
                steps_next = steps_st;
                busy_next  = steps_st != '0;
                out_next   = '{pixel_x: x_st, pixel_y: y_st, pixel_color: color_reg,
                               pixel_valid: 1'b1, last_pixel: steps_st == '0};
            end else begin
                out_next = '0;
            end
        end else if (cmd.div_load) begin
            estep_next = quotient;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        x_neg_reg <= x_neg_next;
        steps_reg <= steps_next;
        acc_reg   <= acc_next;
        estep_reg <= estep_next;
        mode_reg  <= mode_next;
        color_reg <= color_next;
        out_reg   <= out_next;
    end

    assign m_data = out_reg;

    lr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .numer    (minor),
        .denom    (major),
        .busy     (div_busy),
        .quotient (quotient)
    );

endmodule

// File: rtl/lr_ctrl.sv
// ----------------------------------------------------------------------------
// Line rasteriser controller
// Handshake control and the wait for the slope divide after a line start.
// ----------------------------------------------------------------------------
module lr_ctrl
    import lr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  lr_stat_t stat,
    output lr_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_READY = 2'b01,
        ST_DIV   = 2'b10
    } lr_state_t;

    lr_state_t state_reg, state_next;
    logic      m_valid_reg, m_valid_next;
    logic      out_free;

    // The result register takes a new item when empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_READY) && out_free;

    always_comb begin
        cmd.accept    = s_valid && s_ready;
        cmd.div_start = cmd.accept && stat.need_div;
        cmd.div_load  = (state_reg == ST_DIV) && !stat.div_busy;

        state_next = state_reg;
        unique case (state_reg)
            ST_READY: begin
                if (cmd.div_start) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!stat.div_busy) begin
                    state_next = ST_READY;
                end
            end
            default: begin
                state_next = ST_READY;
            end
        endcase

        m_valid_next = cmd.accept || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_READY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: bench/tb_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Line rasteriser testbench
// Drives start and step items into line_rasterizer through a burst-and-gap
// driver, predicts every pixel with a behavioural model of the error
// accumulator walk, and checks each result field by field as it leaves the
// block under a randomly stalling receiver.
// ----------------------------------------------------------------------------
module tb_line_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import lr_pkg::*;

    localparam int FRAC_W = 16;
    localparam logic CMD_STEP = ~CMD_START;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 3 * (FRAC_W + 1);
    localparam int RUN_ITEMS = 2000;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    lr_in_t  s_data = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    lr_out_t m_data;

    line_rasterizer #(
        .FRAC_BITS(FRAC_W)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    lr_in_t  pending_items[$];
    lr_out_t expected_pixels[$];

    int items_total = 0;
    int items_sent = 0;
    int results_seen = 0;
    int error_count = 0;
    int lines_started = 0;
    int lines_cut = 0;
    int idle_steps = 0;
    int line_ends = 0;

    // Model state of the pixel walk.
    lr_coord_t         pen_x = '0;
    lr_coord_t         pen_y = '0;
    logic              walk_left = 1'b0;
    lr_coord_t         steps_to_go = '0;
    logic [FRAC_W-1:0] err_acc = '0;
    logic [FRAC_W-1:0] err_inc = '0;
    lr_mode_t          line_kind = MODE_HORIZ;
    lr_color_t         pen_color = '0;
    logic              drawing = 1'b0;

    // Adds the slope to the accumulator; the minor axis moves when it wraps.
    function automatic logic err_wraps();
        logic [FRAC_W-1:0] prev;
        prev = err_acc;
        err_acc = err_acc + err_inc;
        return err_acc <= prev;
    endfunction

    function automatic lr_out_t predict_pixel(lr_in_t item);
        lr_coord_t   x0, y0, x1, y1, dx, dy, major, minor;
        logic [31:0] quot;
        lr_out_t     res;
        res = '0;
        if (item.command == CMD_START) begin
            lines_started++;
            if (drawing) begin
                lines_cut++;
            end
            if (item.y_start > item.y_end) begin
                x0 = item.x_end;   y0 = item.y_end;
                x1 = item.x_start; y1 = item.y_start;
            end else begin
                x0 = item.x_start; y0 = item.y_start;
                x1 = item.x_end;   y1 = item.y_end;
            end
            dy = y1 - y0;
            walk_left = (x1 < x0);
            dx = walk_left ? x0 - x1 : x1 - x0;
            pen_color = item.line_color;
            pen_x = x0;
            pen_y = y0;
            err_acc = '0;
            err_inc = '0;
            if (dy == 0) begin
                line_kind = MODE_HORIZ;
                steps_to_go = dx;
            end else if (dx == 0) begin
                line_kind = MODE_VERT;
                steps_to_go = dy;
            end else begin
                if (dy > dx) begin
                    line_kind = MODE_STEEP;
                    major = dy;
                    minor = dx;
                end else begin
                    line_kind = MODE_SHALLOW;
                    major = dx;
                    minor = dy;
                end
                steps_to_go = major;
                quot = (32'(minor) << FRAC_W) / 32'(major);
                err_inc = quot[FRAC_W-1:0];
            end
            drawing = (steps_to_go != 0);
        end else if (!drawing) begin
            idle_steps++;
            return res;
        end else begin
            case (line_kind)
                MODE_HORIZ: begin
                    pen_x = walk_left ? pen_x - 1'b1 : pen_x + 1'b1;
                end
                MODE_VERT: begin
                    pen_y = pen_y + 1'b1;
                end
                MODE_STEEP: begin
                    if (err_wraps()) begin
                        pen_x = walk_left ? pen_x - 1'b1 : pen_x + 1'b1;
                    end
                    pen_y = pen_y + 1'b1;
                end
                default: begin
                    if (err_wraps()) begin
                        pen_y = pen_y + 1'b1;
                    end
                    pen_x = walk_left ? pen_x - 1'b1 : pen_x + 1'b1;
                end
            endcase
            steps_to_go = steps_to_go - 1'b1;
            drawing = (steps_to_go != 0);
        end
        res.pixel_x = pen_x;
        res.pixel_y = pen_y;
        res.pixel_color = pen_color;
        res.pixel_valid = 1'b1;
        res.last_pixel = !drawing;
        return res;
    endfunction

    // ---------------- Stimulus construction ----------------

    function automatic lr_in_t random_item();
        lr_in_t item;
        item.command = 1'($urandom_range(0, 1));
        item.x_start = lr_coord_t'($urandom_range(0, 1023));
        item.y_start = lr_coord_t'($urandom_range(0, 1023));
        item.x_end = lr_coord_t'($urandom_range(0, 1023));
        item.y_end = lr_coord_t'($urandom_range(0, 1023));
        item.line_color = lr_color_t'($urandom_range(0, 255));
        return item;
    endfunction

    function automatic int line_span(lr_coord_t xs, lr_coord_t ys, lr_coord_t xe,
                                     lr_coord_t ye);
        int dx, dy;
        dx = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
        dy = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
        return (dx > dy) ? dx : dy;
    endfunction

    // Queues a start followed by a number of step items with random payload.
    task automatic queue_line(lr_coord_t xs, lr_coord_t ys, lr_coord_t xe, lr_coord_t ye,
                              lr_color_t col, int steps);
        lr_in_t item;
        item.command = CMD_START;
        item.x_start = xs;
        item.y_start = ys;
        item.x_end = xe;
        item.y_end = ye;
        item.line_color = col;
        pending_items.push_back(item);
        for (int i = 0; i < steps; i++) begin
            item = random_item();
            item.command = CMD_STEP;
            pending_items.push_back(item);
        end
    endtask

    task automatic queue_random_line();
        lr_coord_t xs, ys, xe, ye;
        int        dx, dy, span, r;
        xs = lr_coord_t'($urandom_range(0, 1023));
        ys = lr_coord_t'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        span = (r < 90) ? 12 : 100;
        dx = $urandom_range(0, span);
        dy = $urandom_range(0, span);
        case ($urandom_range(0, 3))
            0: dy = 0;
            1: dx = 0;
            2: dy = dx;
            default: ;
        endcase
        xe = lr_coord_t'(int'(xs) + ($urandom_range(0, 1) ? -dx : dx));
        ye = lr_coord_t'(int'(ys) + ($urandom_range(0, 1) ? -dy : dy));
        span = line_span(xs, ys, xe, ye);
        r = $urandom_range(0, 9);
        if (r == 0 && span > 1) begin
            // Cut short: the next start abandons this line.
            span = $urandom_range(0, span - 1);
        end else if (r == 1) begin
            span = span + $urandom_range(1, 3);
        end
        queue_line(xs, ys, xe, ye, lr_color_t'($urandom_range(0, 255)), span);
    endtask

    // ---------------- Driver ----------------

    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            burst_left = $urandom_range(1, 24);
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pixels.push_back(predict_pixel(s_data));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- Receiver stalls ----------------

    rx_pattern_t rx_pattern = RX_OPEN;
    int          rx_left = 0;
    int          rx_tick = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_left = 0;
        end else begin
            if (rx_left == 0) begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_left = $urandom_range(40, 300);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_pattern)
                RX_OPEN:     m_ready <= 1'b1;
                RX_LIGHT:    m_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:    m_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_ready <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    // ---------------- Monitor ----------------

    task automatic report_mismatch(string detail);
        $display("%0t ns: result %0d: %s", $time, results_seen, detail);
        error_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        lr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result (%0d,%0d) with no item pending",
                                          m_data.pixel_x, m_data.pixel_y));
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel_x", 32'(m_data.pixel_x), 32'(want.pixel_x));
                check_field("pixel_y", 32'(m_data.pixel_y), 32'(want.pixel_y));
                check_field("pixel_color", 32'(m_data.pixel_color), 32'(want.pixel_color));
                check_field("pixel_valid", 32'(m_data.pixel_valid), 32'(want.pixel_valid));
                check_field("last_pixel", 32'(m_data.last_pixel), 32'(want.last_pixel));
                if (want.last_pixel) begin
                    line_ends++;
                end
            end
            results_seen++;
        end
    end

    // ---------------- Watchdog ----------------

    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Stalled with %0d items unsent and %0d results outstanding.",
                         pending_items.size() + (s_valid ? 1 : 0), expected_pixels.size());
                $display("[line_rasterizer] ERROR");
                $finish;
            end
        end
    end

    // ---------------- Sequence ----------------

    initial begin
        int directed_end;

        // Step with nothing drawn, all payload bits set.
        pending_items.push_back('{CMD_STEP, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255});
        // Single point at the far corner.
        queue_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255, 1);
        // Horizontal to the right, ending at the last column.
        queue_line(10'd1020, 10'd7, 10'd1023, 10'd7, 8'd0, 3);
        // Horizontal to the left on the bottom row.
        queue_line(10'd3, 10'd1023, 10'd0, 10'd1023, 8'd170, 3);
        // Vertical given bottom first, so the endpoints swap.
        queue_line(10'd5, 10'd9, 10'd5, 10'd6, 8'd85, 3);
        // Exact diagonal from the origin.
        queue_line(10'd0, 10'd0, 10'd2, 10'd2, 8'd1, 2);
        // Steep line walking left.
        queue_line(10'd10, 10'd0, 10'd9, 10'd3, 8'd128, 3);
        // Shallow line abandoned after one step by the next start.
        queue_line(10'd0, 10'd0, 10'd3, 10'd1, 8'd127, 1);
        directed_end = pending_items.size();

        // One full-width shallow line, then short random lines and noise.
        queue_line(10'd1023, 10'd0, 10'd0, 10'd700, 8'h5a, 1023);
        while (pending_items.size() < RUN_ITEMS) begin
            if ($urandom_range(0, 99) < 6) begin
                pending_items.push_back(random_item());
            end else begin
                queue_random_line();
            end
        end
        items_total = pending_items.size();
        $display("%0d directed items ahead of the random sequence.", directed_end);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(items_sent == items_total && expected_pixels.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results from %0d items: %0d lines started, %0d cut short.",
                 results_seen, items_total, lines_started, lines_cut);
        $display("%0d lines ran to their end point; %0d steps arrived with no line active.",
                 line_ends, idle_steps);
        if (error_count == 0) begin
            $display("[line_rasterizer] OK");
        end else begin
            $display("%0d mismatches.", error_count);
            $display("[line_rasterizer] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_div.sv
rtl/lr_datapath.sv
rtl/lr_ctrl.sv
rtl/line_rasterizer.sv
bench/tb_line_rasterizer.sv
